FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the tokenizer RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALW(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CHK(label, prop, msg)
`define ASSERT_ALW(label, prop, msg)

`endif

`endif

FILE: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types, token kind codes, keyword and operator tables for the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int POS_WIDTH_DEF = 16;
  localparam int OUT_WIDTH     = 16;
  localparam int KW_NUM        = 7;
  // output queue depth, power of two
  localparam int OQ_DEPTH      = 4;

  // token kinds
  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_NUMBER  = 5'd2;
  localparam logic [4:0] KIND_STRING  = 5'd3;
  localparam logic [4:0] KIND_KW_BASE = 5'd4;
  localparam logic [4:0] KIND_OP_ASGN = 5'd11;
  localparam logic [4:0] KIND_OP_PLUS = 5'd12;
  localparam logic [4:0] KIND_OP_MINS = 5'd13;
  localparam logic [4:0] KIND_OP_STAR = 5'd14;
  localparam logic [4:0] KIND_OP_SLSH = 5'd15;
  localparam logic [4:0] KIND_OP_SEMI = 5'd16;
  localparam logic [4:0] KIND_OP_COMA = 5'd17;
  localparam logic [4:0] KIND_OP_LPAR = 5'd18;
  localparam logic [4:0] KIND_OP_RPAR = 5'd19;
  localparam logic [4:0] KIND_OP_LBRC = 5'd20;
  localparam logic [4:0] KIND_OP_RBRC = 5'd21;
  localparam logic [4:0] KIND_UNKNOWN = 5'd22;

  // keyword spellings, zero filled to eight bytes
  localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
    '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
    '{"f", "u", "n", "c", "t", "i", "o", "n"},
    '{"c", "l", "a", "s", "s", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{4'd3, 4'd5, 4'd8, 4'd5, 4'd6, 4'd2, 4'd4};

  // one result item
  typedef struct packed {
    logic                 last;
    logic [4:0]           kind;
    logic [OUT_WIDTH-1:0] col;
    logic [OUT_WIDTH-1:0] line;
    logic [OUT_WIDTH-1:0] len;
    logic [OUT_WIDTH-1:0] off;
  } tok_t;

  // tokens produced by one accepted item, slot 0 first
  typedef struct packed {
    logic wr0;
    logic wr1;
    tok_t tok0;
    tok_t tok1;
  } scan_wr_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == " ") || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
  endfunction

  // operator byte to kind, anything else unknown
  function automatic logic [4:0] op_kind(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      "=":     k = KIND_OP_ASGN;
      "+":     k = KIND_OP_PLUS;
      "-":     k = KIND_OP_MINS;
      "*":     k = KIND_OP_STAR;
      "/":     k = KIND_OP_SLSH;
      ";":     k = KIND_OP_SEMI;
      ",":     k = KIND_OP_COMA;
      "(":     k = KIND_OP_LPAR;
      ")":     k = KIND_OP_RPAR;
      "{":     k = KIND_OP_LBRC;
      "}":     k = KIND_OP_RBRC;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // drop keywords whose byte at pos differs or that are no longer than pos
  function automatic logic [KW_NUM-1:0] kw_filter(input logic [KW_NUM-1:0] kw,
                                                  input logic [7:0] b,
                                                  input logic [2:0] pos);
    logic [KW_NUM-1:0] r;
    for (int k = 0; k < KW_NUM; k++) begin
      r[k] = kw[k] && ({1'b0, pos} < KW_LEN[k]) && (KW_TEXT[k][pos] == b);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and per-byte next-state logic; emits up to two tokens per item.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scan
  import stt_pkg::*;
#(
  parameter int POSITION_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end,
  output scan_wr_t        wr
);

  localparam int PW = POSITION_WIDTH;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_STRING = 2'd3;

  localparam logic [PW-1:0] POS_ZERO = '0;
  localparam logic [PW-1:0] POS_ONE  = PW'(1);

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (&v) ? v : PW'(v + 1'b1);
  endfunction

  function automatic logic [OUT_WIDTH-1:0] clamp16(input logic [PW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? {OUT_WIDTH{1'b1}} : w[OUT_WIDTH-1:0];
  endfunction

  // state registers
  logic [1:0]        mode_r, mode_nxt;
  logic              qsingle_r, qsingle_nxt;
  logic [PW-1:0]     soff_r, soff_nxt;
  logic [PW-1:0]     sline_r, sline_nxt;
  logic [PW-1:0]     scol_r, scol_nxt;
  logic [PW-1:0]     len_r, len_nxt;
  logic [PW-1:0]     off_r, off_nxt;
  logic [PW-1:0]     line_r, line_nxt;
  logic [PW-1:0]     col_r, col_nxt;
  logic [KW_NUM-1:0] kw_r, kw_nxt;

  // per-byte classification and helpers
  logic              is_end;
  logic              cont_tok;
  logic              idle_pass;
  logic              emit_a;
  logic              emit_i;
  logic              do_adv;
  logic [4:0]        id_kind;
  logic [KW_NUM-1:0] kw_run;
  logic [7:0]        qchar;
  tok_t              tok_a;
  tok_t              tok_i;

  assign is_end = in_end || (in_byte == 8'h00);
  assign qchar  = qsingle_r ? 8'h27 : 8'h22;

  // keyword match of the open identifier, first hit wins
  always_comb begin
    id_kind = KIND_IDENT;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (kw_r[k] && (len_r == PW'(KW_LEN[k]))) begin
        id_kind = KIND_KW_BASE + 5'(k);
      end
    end
  end

  // filter applied while an identifier grows
  assign kw_run = kw_filter(kw_r, in_byte, len_r[2:0]) & {KW_NUM{len_r < PW'(8)}};

  // next state and token generation
  always_comb begin
    mode_nxt    = mode_r;
    qsingle_nxt = qsingle_r;
    soff_nxt    = soff_r;
    sline_nxt   = sline_r;
    scol_nxt    = scol_r;
    len_nxt     = len_r;
    kw_nxt      = kw_r;
    idle_pass   = 1'b1;
    emit_a      = 1'b0;
    emit_i      = 1'b0;
    do_adv      = 1'b0;
    cont_tok    = 1'b0;
    tok_a       = '0;
    tok_i       = '0;

    // close or extend an open token
    case (mode_r)
      MODE_IDENT, MODE_NUMBER: begin
        if (mode_r == MODE_IDENT) begin
          cont_tok = is_alpha(in_byte) || is_digit(in_byte) || (in_byte == "_");
        end else begin
          cont_tok = is_digit(in_byte) || (in_byte == ".");
        end
        if (!is_end && cont_tok) begin
          if (mode_r == MODE_IDENT) begin
            kw_nxt = kw_run;
          end
          len_nxt   = sat_inc(len_r);
          do_adv    = 1'b1;
          idle_pass = 1'b0;
        end else begin
          emit_a     = 1'b1;
          tok_a.kind = (mode_r == MODE_IDENT) ? id_kind : KIND_NUMBER;
          mode_nxt   = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (is_end || (in_byte == qchar)) begin
          emit_a     = 1'b1;
          tok_a.kind = KIND_STRING;
          mode_nxt   = MODE_IDLE;
          if (!is_end) begin
            do_adv    = 1'b1;
            idle_pass = 1'b0;
          end
        end else begin
          len_nxt   = sat_inc(len_r);
          do_adv    = 1'b1;
          idle_pass = 1'b0;
        end
      end
      default: begin
      end
    endcase
    tok_a.off  = clamp16(soff_r);
    tok_a.len  = clamp16(len_r);
    tok_a.line = clamp16(sline_r);
    tok_a.col  = clamp16(scol_r);

    // current byte between tokens
    tok_i.off  = clamp16(off_r);
    tok_i.line = clamp16(line_r);
    tok_i.col  = clamp16(col_r);
    if (idle_pass) begin
      if (is_end) begin
        emit_i     = 1'b1;
        tok_i.kind = KIND_EOF;
        tok_i.len  = '0;
      end else if (is_space(in_byte)) begin
        do_adv = 1'b1;
      end else if ((in_byte == 8'h22) || (in_byte == 8'h27)) begin
        mode_nxt    = MODE_STRING;
        qsingle_nxt = (in_byte == 8'h27);
        soff_nxt    = sat_inc(off_r);
        sline_nxt   = line_r;
        scol_nxt    = col_r;
        len_nxt     = POS_ZERO;
        kw_nxt      = '1;
        do_adv      = 1'b1;
      end else if (is_alpha(in_byte) || (in_byte == "_")) begin
        mode_nxt  = MODE_IDENT;
        soff_nxt  = off_r;
        sline_nxt = line_r;
        scol_nxt  = col_r;
        len_nxt   = POS_ONE;
        kw_nxt    = kw_filter('1, in_byte, 3'd0);
        do_adv    = 1'b1;
      end else if (is_digit(in_byte)) begin
        mode_nxt  = MODE_NUMBER;
        soff_nxt  = off_r;
        sline_nxt = line_r;
        scol_nxt  = col_r;
        len_nxt   = POS_ONE;
        kw_nxt    = '1;
        do_adv    = 1'b1;
      end else begin
        emit_i     = 1'b1;
        tok_i.kind = op_kind(in_byte);
        tok_i.len  = OUT_WIDTH'(1);
        do_adv     = 1'b1;
      end
    end

    // position advance over the consumed byte
    off_nxt  = off_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    if (do_adv) begin
      off_nxt = sat_inc(off_r);
      if (in_byte == 8'h0A) begin
        line_nxt = sat_inc(line_r);
        col_nxt  = POS_ONE;
      end else begin
        col_nxt = sat_inc(col_r);
      end
    end

    // end of source returns everything to the reset state
    if (idle_pass && is_end) begin
      mode_nxt    = MODE_IDLE;
      qsingle_nxt = 1'b0;
      soff_nxt    = POS_ZERO;
      sline_nxt   = POS_ONE;
      scol_nxt    = POS_ONE;
      len_nxt     = POS_ZERO;
      off_nxt     = POS_ZERO;
      line_nxt    = POS_ONE;
      col_nxt     = POS_ONE;
      kw_nxt      = '1;
    end
  end

  // token slots, last flag on the final one
  always_comb begin
    wr      = '0;
    wr.tok0 = emit_a ? tok_a : tok_i;
    wr.tok1 = tok_i;
    wr.tok0.last = !(emit_a && emit_i);
    wr.tok1.last = 1'b1;
    wr.wr0  = in_fire && (emit_a || emit_i);
    wr.wr1  = in_fire && emit_a && emit_i;
  end

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      qsingle_r <= 1'b0;
      soff_r    <= POS_ZERO;
      sline_r   <= POS_ONE;
      scol_r    <= POS_ONE;
      len_r     <= POS_ZERO;
      off_r     <= POS_ZERO;
      line_r    <= POS_ONE;
      col_r     <= POS_ONE;
      kw_r      <= '1;
    end else if (in_fire) begin
      mode_r    <= mode_nxt;
      qsingle_r <= qsingle_nxt;
      soff_r    <= soff_nxt;
      sline_r   <= sline_nxt;
      scol_r    <= scol_nxt;
      len_r     <= len_nxt;
      off_r     <= off_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      kw_r      <= kw_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/stt_outq.sv
// ----------------------------------------------------------------------------
// stt_outq
// Small token queue: up to two in a cycle, one out a cycle while out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_outq
  import stt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire scan_wr_t wr,
  output logic          room,
  output logic          out_valid,
  input  wire logic     out_ready,
  output tok_t          out_tok
);

  localparam int AW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  tok_t           mem_r [OQ_DEPTH];
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           pop;
  logic [AW-1:0]  wr_ptr_p1;

  assign out_valid = (count_r != '0);
  assign out_tok   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room      = (count_r <= CW'(OQ_DEPTH - 2));
  assign wr_ptr_p1 = AW'(wr_ptr_r + 1'b1);

  // pointer and fill count bookkeeping
  always_comb begin
    rd_ptr_nxt = pop ? AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    wr_ptr_nxt = wr.wr1 ? AW'(wr_ptr_r + 2'd2) : (wr.wr0 ? wr_ptr_p1 : wr_ptr_r);
    count_nxt  = CW'(count_r + CW'(wr.wr0) + CW'(wr.wr1) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (wr.wr0) begin
      mem_r[wr_ptr_r] <= wr.tok0;
    end
    if (wr.wr1) begin
      mem_r[wr_ptr_p1] <= wr.tok1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/source_text_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming lexical tokenizer: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one source byte per item; in_tlast (or a zero byte) ends the
//           source and yields any open token followed by an EOF token.
//   out_* : one token per item; out_tuser is the token kind, out_tlast marks
//           the final token produced by one input item.
// Output path: tokens of an accepted item are written into the registered
//   token queue and reach out_* behind any tokens still queued.
// Throughput: one input byte per cycle while in_tready is high, set by the
//   single-pass scanner state update. The output side moves one token per
//   cycle while out_tready is high, so a byte that closes a token and starts
//   an operator or EOF yields two tokens; a four-entry token queue absorbs this.
// Stall: in_tready drops while fewer than two queue entries are free, i.e.
//   three or more tokens wait. Bytes that yield no token keep flowing under
//   a stalled receiver until that many tokens have piled up.
// Reset: synchronous rst_n clears the scanner to line 1, column 1, offset 0
//   and empties the queue. After each EOF token the scanner returns to the
//   same state and the next byte starts a new source.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module source_text_tokenizer_unit
  import stt_pkg::*;
#(
  parameter int POSITION_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // source_byte
  input  wire logic        in_tlast,   // end_of_source
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // lexeme_offset, lexeme_length, line_number,
                                       // column_number
  output logic [4:0]       out_tuser,  // token_kind
  output logic             out_tlast   // last_in_run
);

  scan_wr_t wr;
  tok_t     out_tok;
  logic     in_fire;
  logic     room;
  logic     eof_out;

  assign in_tready = room;
  assign in_fire   = in_tvalid && in_tready;

  // scanner
  stt_scan #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_end  (in_tlast),
    .wr      (wr)
  );

  // token queue
  stt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (out_tok)
  );

  // output packing
  assign out_tdata = {out_tok.col, out_tok.line, out_tok.len, out_tok.off};
  assign out_tuser = out_tok.kind;
  assign out_tlast = out_tok.last;

  // eof token on the output
  assign eof_out = out_tvalid && (out_tuser == KIND_EOF);

  // checks
  `ASSERT_ALW(a_empty_after_reset, !rst_n |=> !out_tvalid, "output valid right after reset")
  `ASSERT_CHK(a_wr_on_accept, wr.wr0 |-> in_fire, "token written without accepted item")
  `ASSERT_CHK(a_pair_order, wr.wr1 |-> (wr.wr0 && !wr.tok0.last && wr.tok1.last), "bad pair")
  `ASSERT_CHK(a_eof_shape, eof_out |-> (out_tlast && out_tdata[31:16] == 16'd0), "bad eof")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for source_text_tokenizer_unit. Source bytes go in with
// random bursts and gaps while the token side stalls on its own pattern. Each
// accepted byte runs through a local scanner model, and every token that comes
// out is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import stt_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RANDOM_ITEMS = 1400;
  localparam int LONG_RUN = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int SHOW_LIMIT = 10;
  localparam logic [15:0] POS_LIMIT = 16'hFFFF;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  // operator bytes in kind order, first one in the top byte
  localparam logic [87:0] OP_CHARS = "=+-*/;,(){}";
  // keyword spellings right aligned, in kind order
  localparam logic [71:0] KW_WORDS [7] = '{"let", "const", "function", "class",
                                           "return", "if", "else"};

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING} scan_mode_e;
  typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_style_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  source_text_tokenizer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // scanner model state
  scan_mode_e  lex_mode;
  logic        quote_single;
  logic [15:0] tok_off, tok_line, tok_col, tok_len;
  logic [15:0] src_off, src_line, src_col;
  logic [71:0] ident_head;

  tok_t pending_tokens[$];
  int   error_count = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;

  ready_style_e ready_style = READY_ALWAYS;
  int           style_left = 0;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == " " || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == POS_LIMIT) ? v : v + 16'd1;
  endfunction

  function automatic logic [4:0] op_code(input logic [7:0] b);
    logic [4:0] kind;
    kind = KIND_UNKNOWN;
    for (int i = 0; i < 11; i++) begin
      if (OP_CHARS[8*(10-i) +: 8] == b) kind = KIND_OP_ASGN + 5'(i);
    end
    return kind;
  endfunction

  function automatic logic [4:0] word_kind();
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < 7; k++) begin
      if (tok_len <= 16'd8 && ident_head == KW_WORDS[k]) kind = KIND_KW_BASE + 5'(k);
    end
    return kind;
  endfunction

  function automatic tok_t build_token(input logic [4:0] kind, input logic [15:0] off,
                                       input logic [15:0] len, input logic [15:0] line,
                                       input logic [15:0] col);
    tok_t t;
    t.last = 1'b0;
    t.kind = kind;
    t.off = off;
    t.len = len;
    t.line = line;
    t.col = col;
    return t;
  endfunction

  task automatic clear_scanner();
    lex_mode = SCAN_IDLE;
    quote_single = 1'b0;
    tok_off = 16'd0;
    tok_line = 16'd1;
    tok_col = 16'd1;
    tok_len = 16'd0;
    src_off = 16'd0;
    src_line = 16'd1;
    src_col = 16'd1;
    ident_head = '0;
  endtask

  task automatic move_past(input logic [7:0] b);
    src_off = bump(src_off);
    if (b == CH_LF) begin
      src_line = bump(src_line);
      src_col = 16'd1;
    end else begin
      src_col = bump(src_col);
    end
  endtask

  task automatic start_token(input scan_mode_e mode);
    lex_mode = mode;
    tok_off = src_off;
    tok_line = src_line;
    tok_col = src_col;
    tok_len = 16'd0;
    ident_head = '0;
  endtask

  // tokens caused by one source byte, queued in output order
  task automatic tokenize_byte(input logic [7:0] b, input logic eos);
    tok_t found[2];
    int   nf;
    logic stop;
    logic taken;
    logic grows;
    logic [7:0] closer;
    nf = 0;
    taken = 1'b0;
    stop = eos || (b == 8'h00);
    // an open identifier or number grows or closes on this byte
    if (lex_mode == SCAN_IDENT || lex_mode == SCAN_NUMBER) begin
      if (lex_mode == SCAN_IDENT) grows = is_letter(b) || is_numeral(b) || b == "_";
      else grows = is_numeral(b) || b == ".";
      if (!stop && grows) begin
        ident_head = {ident_head[63:0], b};
        tok_len = bump(tok_len);
        move_past(b);
        taken = 1'b1;
      end else begin
        found[nf] = build_token((lex_mode == SCAN_IDENT) ? word_kind() : KIND_NUMBER,
                                tok_off, tok_len, tok_line, tok_col);
        nf++;
        lex_mode = SCAN_IDLE;
      end
    end else if (lex_mode == SCAN_STRING) begin
      closer = quote_single ? CH_SQUOTE : CH_DQUOTE;
      if (stop || b == closer) begin
        found[nf] = build_token(KIND_STRING, tok_off, tok_len, tok_line, tok_col);
        nf++;
        lex_mode = SCAN_IDLE;
        if (!stop) begin
          move_past(b);
          taken = 1'b1;
        end
      end else begin
        tok_len = bump(tok_len);
        move_past(b);
        taken = 1'b1;
      end
    end
    // a byte not used above is handled from idle
    if (!taken) begin
      if (stop) begin
        found[nf] = build_token(KIND_EOF, src_off, 16'd0, src_line, src_col);
        nf++;
        clear_scanner();
      end else if (is_blank(b)) begin
        move_past(b);
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        start_token(SCAN_STRING);
        quote_single = (b == CH_SQUOTE);
        move_past(b);
        tok_off = src_off;
      end else if (is_letter(b) || b == "_") begin
        start_token(SCAN_IDENT);
        ident_head = {64'h0, b};
        tok_len = 16'd1;
        move_past(b);
      end else if (is_numeral(b)) begin
        start_token(SCAN_NUMBER);
        tok_len = 16'd1;
        move_past(b);
      end else begin
        found[nf] = build_token(op_code(b), src_off, 16'd1, src_line, src_col);
        nf++;
        move_past(b);
      end
    end
    if (nf > 0) found[nf-1].last = 1'b1;
    for (int i = 0; i < nf; i++) pending_tokens.insert(pending_tokens.size(), found[i]);
  endtask

  // predict on every accepted item
  always @(posedge clk) begin
    if (!rst_n) clear_scanner();
    else if (in_tvalid && in_tready) tokenize_byte(in_tdata, in_tlast);
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= SHOW_LIMIT) $display("%s", msg);
  endtask

  // compare each accepted token with the oldest prediction
  always @(posedge clk) begin : token_check
    tok_t want;
    tok_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = build_token(out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[47:32],
                        out_tdata[63:48]);
      got.last = out_tlast;
      if (pending_tokens.size() == 0) begin
        note_error($sformatf("unexpected token: kind %0d off %0d len %0d line %0d col %0d",
                             got.kind, got.off, got.len, got.line, got.col));
      end else begin
        want = pending_tokens.pop_front();
        if (got !== want) begin
          note_error($sformatf({"token mismatch: expected kind %0d off %0d len %0d ",
                                "line %0d col %0d last %0b, got kind %0d off %0d ",
                                "len %0d line %0d col %0d last %0b"},
                               want.kind, want.off, want.len, want.line, want.col,
                               want.last, got.kind, got.off, got.len, got.line,
                               got.col, got.last));
        end
      end
    end
  end

  // receiver readiness follows a style that is picked anew at random
  always @(posedge clk) begin
    if (style_left == 0) begin
      ready_style <= ready_style_e'($urandom_range(0, 2));
      style_left <= $urandom_range(16, 96);
    end else begin
      style_left <= style_left - 1;
    end
    case (ready_style)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_RANDOM: out_tready <= 1'($urandom);
      default:      out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // one source byte, after a random gap at the start of each burst
  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        in_tvalid <= 1'b0;
        in_tdata <= 8'($urandom);
        in_tlast <= 1'($urandom);
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic end_source(input logic by_zero);
    if (by_zero) send_item(8'h00, 1'b0);
    else send_item(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] word_byte();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // text for one token or a blank run, keywords and near misses favored
  task automatic send_token_text();
    logic [71:0] kw;
    logic [7:0]  c;
    logic [7:0]  q;
    int variant;
    bit first;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        kw = KW_WORDS[$urandom_range(0, 6)];
        variant = $urandom_range(0, 5);
        first = 1'b1;
        for (int i = 8; i >= 0; i--) begin
          c = kw[8*i +: 8];
          if (c != 8'h00 && !(variant == 4 && i == 0)) begin
            send_item((variant == 5 && first) ? c - 8'd32 : c, 1'b0);
            first = 1'b0;
          end
        end
        if (variant == 3) send_item(word_byte(), 1'b0);
      end
      3: begin
        send_item(($urandom_range(0, 4) == 0) ? 8'("_") : 8'("a" + $urandom_range(0, 25)),
                  1'b0);
        repeat ($urandom_range(0, ($urandom_range(0, 9) == 0) ? 40 : 10))
          send_item(word_byte(), 1'b0);
      end
      4: begin
        send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
        repeat ($urandom_range(0, 8))
          send_item(($urandom_range(0, 3) == 0) ? 8'(".") : 8'("0" + $urandom_range(0, 9)),
                    1'b0);
      end
      5: begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        send_item(q, 1'b0);
        repeat ($urandom_range(0, 12)) begin
          do c = 8'($urandom_range(1, 255)); while (c == q);
          send_item(c, 1'b0);
        end
        if ($urandom_range(0, 7) != 0) send_item(q, 1'b0);
      end
      6, 7: send_item(OP_CHARS[8*$urandom_range(0, 10) +: 8], 1'b0);
      8: send_item(8'($urandom_range(1, 255)), 1'b0);
      default: repeat ($urandom_range(1, 3)) send_item(blank_byte(), 1'b0);
    endcase
  endtask

  task automatic send_program();
    repeat ($urandom_range(1, 24)) begin
      send_token_text();
      if ($urandom_range(0, 2) != 0) send_item(blank_byte(), 1'b0);
    end
    end_source($urandom_range(0, 1));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 30))
      send_item(8'($urandom), ($urandom_range(0, 19) == 0));
  endtask

  // every operator, bytes with the top bit set, end flag with a junk byte
  task automatic test_operators();
    send_text("=+-*/;,(){}");
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    end_source(1'b0);
  endtask

  // tokens closed by the next byte, a quoted string holding LF, zero byte end
  task automatic test_boundaries();
    send_text("if9 7.b;'a");
    send_item(CH_LF, 1'b0);
    send_text("\"'");
    end_source(1'b1);
  endtask

  // string still open when the source ends
  task automatic test_open_string();
    send_text("\"ab");
    end_source(1'b0);
  endtask

  // long identifier and long run of LF, back to back
  task automatic test_long_runs();
    gaps_on = 1'b0;
    send_item("a", 1'b0);
    repeat (LONG_RUN - 1) send_item(word_byte(), 1'b0);
    send_item("+", 1'b0);
    repeat (LONG_RUN) send_item(CH_LF, 1'b0);
    send_item("-", 1'b0);
    end_source(1'b0);
    gaps_on = 1'b1;
  endtask

  // mostly well formed sources with random content, some raw noise
  task automatic test_random_sources();
    int stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_program();
    end
    end_source($urandom_range(0, 1));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_operators();
    test_boundaries();
    test_open_string();
    test_random_sources();
    test_long_runs();
    in_tvalid <= 1'b0;
    // let the prediction of the last item land first
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // hang guard
  initial begin
    #(CLK_PERIOD * 2000000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
